>>> hw/rtl/pfp_pkg.sv
// Shared types and constants of the protobuf varint field patcher.
`default_nettype none

package pfp_pkg;

	localparam int LENGTH_BITS_DEF = 32;

	localparam logic [4:0] PATCH_FIELD_RST = 5'd3;
	localparam logic [7:0] PATCH_VALUE_RST = 8'h05;

	localparam logic [7:0] OUTER_TAG_BYTE = 8'h0A;
	localparam logic [2:0] WT_VARINT      = 3'd0;
	localparam logic [2:0] WT_LEN         = 3'd2;

	// configuration register indexes
	localparam logic CFG_PATCH_FIELD = 1'b0;
	localparam logic CFG_PATCH_VALUE = 1'b1;

	typedef struct packed {
		logic [15:0] patch_count;
		logic        stopped;
		logic        patched;
		logic        keep;
		logic [7:0]  out_byte;
	} result_t;

endpackage

`default_nettype wire

>>> hw/rtl/pfp_parser.sv
// Wire-format parser: per-byte state update and patch decision.
`default_nettype none

module pfp_parser #(
	parameter int LENGTH_BITS = pfp_pkg::LENGTH_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last,
	input  wire logic [4:0]       patch_field,
	input  wire logic [7:0]       patch_value,
	output pfp_pkg::result_t      res
);
	import pfp_pkg::*;

	typedef enum logic [2:0] {
		M_OUTER_TAG,
		M_OUTER_LEN,
		M_INNER_TAG,
		M_VARINT,
		M_INNER_LEN,
		M_SKIP,
		M_COPY,
		M_STOPPED
	} mode_t;

	mode_t                  mode_q, mode_d;
	logic [LENGTH_BITS-1:0] entry_q, entry_d;
	logic [LENGTH_BITS-1:0] acc_q, acc_d;
	logic [5:0]             shift_q, shift_d;
	logic [LENGTH_BITS-1:0] skip_q, skip_d;
	logic [4:0]             field_q, field_d;
	logic [15:0]            cnt_q, cnt_d;

	logic [LENGTH_BITS-1:0] acc_or;
	logic [5:0]             shift_sat;
	logic [LENGTH_BITS-1:0] skip_dec;
	logic [LENGTH_BITS-1:0] entry_dec;
	logic                   inner;

	// groups landing at or above LENGTH_BITS fall off the top of the shift
	assign acc_or    = acc_q | (LENGTH_BITS'(data_byte[6:0]) << shift_q);
	assign shift_sat = (shift_q >= 6'd56) ? 6'd63 : shift_q + 6'd7;
	assign skip_dec  = (skip_q != '0) ? skip_q - LENGTH_BITS'(1) : skip_q;
	assign entry_dec = (entry_q != '0) ? entry_q - LENGTH_BITS'(1) : entry_q;

	always_comb begin
		mode_d       = mode_q;
		entry_d      = entry_q;
		acc_d        = acc_q;
		shift_d      = shift_q;
		skip_d       = skip_q;
		field_d      = field_q;
		cnt_d        = cnt_q;
		inner        = 1'b0;
		res.out_byte = data_byte;
		res.keep     = 1'b1;
		res.patched  = 1'b0;
		res.stopped  = 1'b0;

		case (mode_q)
			M_OUTER_TAG: begin
				if (data_byte == OUTER_TAG_BYTE) begin
					mode_d  = M_OUTER_LEN;
					acc_d   = '0;
					shift_d = '0;
				end else begin
					mode_d       = M_STOPPED;
					res.keep     = 1'b0;
					res.out_byte = '0;
					res.stopped  = 1'b1;
				end
			end
			M_OUTER_LEN: begin
				acc_d   = acc_or;
				shift_d = shift_sat;
				if (!data_byte[7]) begin
					entry_d = acc_or;
					mode_d  = (acc_or == '0) ? M_OUTER_TAG : M_INNER_TAG;
				end
			end
			M_INNER_TAG: begin
				inner   = 1'b1;
				field_d = data_byte[7:3];
				if (data_byte[2:0] == WT_VARINT) begin
					mode_d  = M_VARINT;
					shift_d = '0;
				end else if (data_byte[2:0] == WT_LEN) begin
					mode_d  = M_INNER_LEN;
					acc_d   = '0;
					shift_d = '0;
				end else begin
					mode_d = M_COPY;
				end
			end
			M_VARINT: begin
				inner = 1'b1;
				// shift of zero marks the first byte of the varint
				if (shift_q == '0) begin
					if (field_q == patch_field) begin
						res.out_byte = patch_value;
						res.patched  = 1'b1;
						if (cnt_q != '1)
							cnt_d = cnt_q + 16'd1;
					end
					shift_d = 6'd7;
				end
				if (!data_byte[7])
					mode_d = M_INNER_TAG;
			end
			M_INNER_LEN: begin
				inner   = 1'b1;
				acc_d   = acc_or;
				shift_d = shift_sat;
				if (!data_byte[7]) begin
					skip_d = acc_or;
					mode_d = (acc_or == '0) ? M_INNER_TAG : M_SKIP;
				end
			end
			M_SKIP: begin
				inner  = 1'b1;
				skip_d = skip_dec;
				if (skip_dec == '0)
					mode_d = M_INNER_TAG;
			end
			M_COPY: begin
				inner = 1'b1;
			end
			default: begin
				res.keep     = 1'b0;
				res.out_byte = '0;
				res.stopped  = 1'b1;
			end
		endcase

		// entry length runs out even mid-field
		if (inner) begin
			entry_d = entry_dec;
			if (entry_dec == '0)
				mode_d = M_OUTER_TAG;
		end

		if (last) begin
			mode_d  = M_OUTER_TAG;
			entry_d = '0;
			acc_d   = '0;
			shift_d = '0;
			skip_d  = '0;
			field_d = '0;
		end

		res.patch_count = cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_OUTER_TAG;
			entry_q <= '0;
			acc_q   <= '0;
			shift_q <= '0;
			skip_q  <= '0;
			field_q <= '0;
			cnt_q   <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			entry_q <= entry_d;
			acc_q   <= acc_d;
			shift_q <= shift_d;
			skip_q  <= skip_d;
			field_q <= field_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/protobuf_varint_field_patcher.sv
// Top level: stream ports, configuration registers and result register.
//
// Usage
//   Input stream: one byte of a serialized message per word on s_tdata,
//   s_tlast on the final byte of the message. Output stream: one word per
//   input word, carrying the byte (patched or copied), keep/patched/stopped
//   flags and the running saturating patch count.
//   Each word taken is registered in the result register and offered on m_*
//   from the clock edge that takes it onward. Throughput is one word per
//   cycle while m_tready stays high; the parser update is a single pass of
//   combinational logic between the input handshake and the result register.
//   Stalls: the result register holds its word while m_tready is low;
//   s_tready follows as "result register empty or being drained", so a new
//   word enters in the same cycle the old result leaves.
//   Reset (arst_n low): parser back to expecting an outer tag, all lengths
//   and the patch count cleared, patch_field = 3, patch_value = 5, no
//   result pending.
//   Configuration: cfg_we writes cfg_data to register cfg_idx (0 patch_field,
//   1 patch_value) at the clock edge; write only while the block is idle.
`default_nettype none

module protobuf_varint_field_patcher #(
	parameter int LENGTH_BITS = pfp_pkg::LENGTH_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] patch_count
	output logic [2:0]       m_tuser,   // [0] keep, [1] patched, [2] stopped
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [7:0]  cfg_data
);
	import pfp_pkg::*;

	logic [4:0] patch_field_q;
	logic [7:0] patch_value_q;
	logic       m_tvalid_q;
	result_t    res_q;
	result_t    res;
	logic       take;

	assign s_tready = !m_tvalid_q || m_tready;
	assign take     = s_tvalid && s_tready;

	pfp_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (take),
		.data_byte  (s_tdata),
		.last       (s_tlast),
		.patch_field(patch_field_q),
		.patch_value(patch_value_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patch_field_q <= PATCH_FIELD_RST;
			patch_value_q <= PATCH_VALUE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_PATCH_FIELD: patch_field_q <= cfg_data[4:0];
				CFG_PATCH_VALUE: patch_value_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	// payload only; no reset needed
	always_ff @(posedge clk) begin
		if (take)
			res_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {res_q.patch_count, res_q.out_byte};
	assign m_tuser  = {res_q.stopped, res_q.patched, res_q.keep};

endmodule

`default_nettype wire
